// File: rtl/ilmu_pkg.sv
// ----------------------------------------------------------------------------
// ilmu_pkg
// Shared types and codes for the Ising lattice Metropolis update unit.
// ----------------------------------------------------------------------------
package ilmu_pkg;

  localparam int SITE_W   = 12;
  localparam int RAND_W   = 16;
  localparam int THR_W    = 17;
  localparam int DE_W     = 5;
  localparam int ENERGY_W = 15;
  localparam int MAG_W    = 14;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic CFG_THR_FOUR  = 1'b0;
  localparam logic CFG_THR_EIGHT = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_COL,
    S_RD_UP,
    S_RD_DOWN,
    S_RD_LEFT,
    S_RD_RIGHT,
    S_EVAL,
    S_WRITE
  } state_t;

  typedef enum logic [2:0] {
    ADDR_CENTRE,
    ADDR_UP,
    ADDR_DOWN,
    ADDR_LEFT,
    ADDR_RIGHT,
    ADDR_CLEAR
  } addr_sel_t;

  typedef struct packed {
    logic      take;
    logic      col_load;
    logic      cap_centre;
    logic      cap_neigh;
    logic      eval;
    logic      commit;
    logic      clear;
    addr_sel_t addr_sel;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_range;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/ilmu_if.sv
// ----------------------------------------------------------------------------
// ilmu_if
// Valid/ready channels carrying proposal words and result words.
// ----------------------------------------------------------------------------
interface ilmu_site_if;
  logic                        valid;
  logic                        ready;
  logic [ilmu_pkg::SITE_W-1:0] site_index;
  logic [ilmu_pkg::RAND_W-1:0] random_value;

  modport source (output valid, site_index, random_value, input ready);
  modport sink (input valid, site_index, random_value, output ready);
endinterface

interface ilmu_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 flipped;
  logic signed [ilmu_pkg::DE_W-1:0]     energy_change;
  logic signed [ilmu_pkg::ENERGY_W-1:0] total_energy;
  logic signed [ilmu_pkg::MAG_W-1:0]    total_magnetization;

  modport source (output valid, flipped, energy_change, total_energy, total_magnetization,
                  input ready);
  modport sink (input valid, flipped, energy_change, total_energy, total_magnetization,
                output ready);
endinterface

// File: rtl/ilmu_spin_ram.sv
// ----------------------------------------------------------------------------
// ilmu_spin_ram
// Single-port one-bit spin memory with registered read data.
// ----------------------------------------------------------------------------
module ilmu_spin_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic          wdata,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/ilmu_ctrl.sv
// ----------------------------------------------------------------------------
// ilmu_ctrl
// Sequencer for the clearing pass, the five spin reads and the write-back.
// ----------------------------------------------------------------------------
module ilmu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ilmu_pkg::status_t   status,
  output ilmu_pkg::cmd_t      cmd
);

  ilmu_pkg::state_t state;
  ilmu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilmu_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.addr_sel = ilmu_pkg::ADDR_CENTRE;
    unique case (state)
      ilmu_pkg::S_CLEAR: begin
        cmd.clear    = 1'b1;
        cmd.addr_sel = ilmu_pkg::ADDR_CLEAR;
        if (status.clear_last) begin
          state_next = ilmu_pkg::S_IDLE;
        end
      end
      ilmu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ilmu_pkg::S_COL;
        end
      end
      ilmu_pkg::S_COL: begin
        cmd.col_load = 1'b1;
        cmd.addr_sel = ilmu_pkg::ADDR_CENTRE;
        state_next   = status.in_range ? ilmu_pkg::S_RD_UP : ilmu_pkg::S_EVAL;
      end
      ilmu_pkg::S_RD_UP: begin
        cmd.cap_centre = 1'b1;
        cmd.addr_sel   = ilmu_pkg::ADDR_UP;
        state_next     = ilmu_pkg::S_RD_DOWN;
      end
      ilmu_pkg::S_RD_DOWN: begin
        cmd.cap_neigh = 1'b1;
        cmd.addr_sel  = ilmu_pkg::ADDR_DOWN;
        state_next    = ilmu_pkg::S_RD_LEFT;
      end
      ilmu_pkg::S_RD_LEFT: begin
        cmd.cap_neigh = 1'b1;
        cmd.addr_sel  = ilmu_pkg::ADDR_LEFT;
        state_next    = ilmu_pkg::S_RD_RIGHT;
      end
      ilmu_pkg::S_RD_RIGHT: begin
        cmd.cap_neigh = 1'b1;
        cmd.addr_sel  = ilmu_pkg::ADDR_RIGHT;
        state_next    = ilmu_pkg::S_EVAL;
      end
      ilmu_pkg::S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ilmu_pkg::S_WRITE;
      end
      ilmu_pkg::S_WRITE: begin
        cmd.addr_sel = ilmu_pkg::ADDR_CENTRE;
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ilmu_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ilmu_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/ilmu_datapath.sv
// ----------------------------------------------------------------------------
// ilmu_datapath
// Site decoding, neighbour addressing, energy evaluation, running totals,
// threshold registers and the result register.
// ----------------------------------------------------------------------------
module ilmu_datapath #(
  parameter int LATTICE_SIDE = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ilmu_pkg::cmd_t                       cmd,
  output ilmu_pkg::status_t                    status,
  input  logic [ilmu_pkg::SITE_W-1:0]          site_index,
  input  logic [ilmu_pkg::RAND_W-1:0]          random_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_flipped,
  output logic signed [ilmu_pkg::DE_W-1:0]     out_energy_change,
  output logic signed [ilmu_pkg::ENERGY_W-1:0] out_total_energy,
  output logic signed [ilmu_pkg::MAG_W-1:0]    out_total_magnetization,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ilmu_pkg::APB_AW-1:0]          paddr,
  input  logic [ilmu_pkg::APB_DW-1:0]          pwdata,
  output logic [ilmu_pkg::APB_DW-1:0]          prdata
);

  localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
  localparam int AW         = $clog2(SITE_COUNT);
  localparam int RW         = $clog2(LATTICE_SIDE);
  localparam int RECIP_SH   = 28;
  localparam int PROD_W     = 40;
  localparam int unsigned RECIP = ((2 ** RECIP_SH) + LATTICE_SIDE - 1) / LATTICE_SIDE;
  localparam int CMP_W      = 17;

  localparam logic [AW-1:0]  SIDE_A     = AW'(LATTICE_SIDE);
  localparam logic [AW-1:0]  ROW_WRAP   = AW'((LATTICE_SIDE - 1) * LATTICE_SIDE);
  localparam logic [AW-1:0]  COL_WRAP   = AW'(LATTICE_SIDE - 1);
  localparam logic [AW-1:0]  CLEAR_LAST = AW'(SITE_COUNT - 1);
  localparam logic [RW-1:0]  LAST_IDX   = RW'(LATTICE_SIDE - 1);
  localparam logic [CMP_W-1:0] SITE_LIM = CMP_W'(SITE_COUNT);
  localparam logic [ilmu_pkg::ENERGY_W-1:0] ENERGY_INIT =
    ilmu_pkg::ENERGY_W'(-2 * SITE_COUNT);
  localparam logic [ilmu_pkg::MAG_W-1:0] MAG_INIT = ilmu_pkg::MAG_W'(-SITE_COUNT);
  localparam logic [ilmu_pkg::THR_W-1:0] THR_INIT = ilmu_pkg::THR_W'(65536);

  logic [ilmu_pkg::THR_W-1:0]    thr_four;
  logic [ilmu_pkg::THR_W-1:0]    thr_eight;
  logic [AW-1:0]                 site_addr;
  logic [ilmu_pkg::RAND_W-1:0]   rnd;
  logic                          in_range;
  logic [RW-1:0]                 row;
  logic [RW-1:0]                 col;
  logic                          centre;
  logic [2:0]                    neigh_count;
  logic [AW-1:0]                 clear_cnt;
  logic                          flip;
  logic [ilmu_pkg::DE_W-1:0]     de;
  logic [ilmu_pkg::ENERGY_W-1:0] energy;
  logic [ilmu_pkg::MAG_W-1:0]    mag;

  logic [PROD_W-1:0]             quot_prod;
  logic [CMP_W-1:0]              site_ext;
  logic [AW-1:0]                 row_base;
  logic [AW-1:0]                 col_full;
  logic [AW-1:0]                 mem_addr;
  logic                          mem_we;
  logic                          mem_wdata;
  logic                          mem_rdata;
  logic [2:0]                    nsum;
  logic [ilmu_pkg::DE_W-1:0]     de_eval;
  logic                          flip_eval;
  logic [ilmu_pkg::ENERGY_W-1:0] energy_next;
  logic [ilmu_pkg::MAG_W-1:0]    mag_next;

  assign site_ext  = CMP_W'(site_index);
  assign quot_prod = PROD_W'(site_index) * PROD_W'(RECIP);
  assign row_base  = AW'(row) * SIDE_A;
  assign col_full  = site_addr - row_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_four  <= THR_INIT;
      thr_eight <= THR_INIT;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ilmu_pkg::CFG_THR_FOUR:  thr_four  <= pwdata[ilmu_pkg::THR_W-1:0];
        ilmu_pkg::CFG_THR_EIGHT: thr_eight <= pwdata[ilmu_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ilmu_pkg::CFG_THR_FOUR:  prdata = ilmu_pkg::APB_DW'(thr_four);
      ilmu_pkg::CFG_THR_EIGHT: prdata = ilmu_pkg::APB_DW'(thr_eight);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      site_addr <= site_ext[AW-1:0];
      rnd       <= random_value;
      in_range  <= site_ext < SITE_LIM;
      row       <= quot_prod[RECIP_SH +: RW];
    end
    if (cmd.col_load) begin
      col <= col_full[RW-1:0];
    end
    if (cmd.cap_centre) begin
      centre <= mem_rdata;
    end
    if (cmd.take) begin
      neigh_count <= '0;
    end else if (cmd.cap_neigh) begin
      neigh_count <= neigh_count + 3'(mem_rdata);
    end
    if (cmd.eval) begin
      de   <= de_eval;
      flip <= flip_eval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear) begin
      clear_cnt <= clear_cnt + AW'(1);
    end
  end

  always_comb begin
    unique case (cmd.addr_sel)
      ilmu_pkg::ADDR_CENTRE: mem_addr = site_addr;
      ilmu_pkg::ADDR_UP:     mem_addr = (row == '0) ? site_addr + ROW_WRAP : site_addr - SIDE_A;
      ilmu_pkg::ADDR_DOWN:   mem_addr = (row == LAST_IDX) ? site_addr - ROW_WRAP
                                                          : site_addr + SIDE_A;
      ilmu_pkg::ADDR_LEFT:   mem_addr = (col == '0) ? site_addr + COL_WRAP
                                                    : site_addr - AW'(1);
      ilmu_pkg::ADDR_RIGHT:  mem_addr = (col == LAST_IDX) ? site_addr - COL_WRAP
                                                          : site_addr + AW'(1);
      ilmu_pkg::ADDR_CLEAR:  mem_addr = clear_cnt;
      default:               mem_addr = site_addr;
    endcase
  end

  assign mem_we    = cmd.clear || (cmd.commit && flip);
  assign mem_wdata = cmd.clear ? 1'b0 : !centre;

  ilmu_spin_ram #(
    .DEPTH (SITE_COUNT),
    .AW    (AW)
  ) u_spin_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    nsum = neigh_count + 3'(mem_rdata);
    if (!in_range) begin
      de_eval = '0;
    end else if (centre) begin
      de_eval = ilmu_pkg::DE_W'({nsum, 2'b00}) - ilmu_pkg::DE_W'(8);
    end else begin
      de_eval = ilmu_pkg::DE_W'(8) - ilmu_pkg::DE_W'({nsum, 2'b00});
    end
    if (!in_range) begin
      flip_eval = 1'b0;
    end else if (de_eval[ilmu_pkg::DE_W-1] || de_eval == '0) begin
      flip_eval = 1'b1;
    end else if (de_eval == ilmu_pkg::DE_W'(4)) begin
      flip_eval = ilmu_pkg::THR_W'(rnd) < thr_four;
    end else begin
      flip_eval = ilmu_pkg::THR_W'(rnd) < thr_eight;
    end
  end

  always_comb begin
    energy_next = energy;
    mag_next    = mag;
    if (flip) begin
      energy_next = energy + {{(ilmu_pkg::ENERGY_W - ilmu_pkg::DE_W){de[ilmu_pkg::DE_W-1]}}, de};
      mag_next    = centre ? mag - ilmu_pkg::MAG_W'(2) : mag + ilmu_pkg::MAG_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= ENERGY_INIT;
      mag    <= MAG_INIT;
    end else if (cmd.commit) begin
      energy <= energy_next;
      mag    <= mag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_flipped             <= flip;
      out_energy_change       <= de;
      out_total_energy        <= energy_next;
      out_total_magnetization <= mag_next;
    end
  end

  assign status.clear_last = clear_cnt == CLEAR_LAST;
  assign status.in_range   = in_range;
  assign status.out_busy   = out_valid && !out_ready;

endmodule

// File: rtl/ising_lattice_metropolis_update_unit.sv
// ----------------------------------------------------------------------------
// ising_lattice_metropolis_update_unit
// Metropolis single-spin update on a periodic square Ising lattice.
// ----------------------------------------------------------------------------
// Each taken proposal word is read through the single-port spin memory (centre,
// up, down, left, right), evaluated and written back; an out-of-range site skips
// the neighbour reads. No new word is taken before the write-back commits.
// Reset: rst is synchronous; a clearing pass then zeroes the spin memory,
// during which no proposal is taken.
module ising_lattice_metropolis_update_unit #(
  parameter int LATTICE_SIDE = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  ilmu_site_if.sink                      site,
  ilmu_result_if.source                  result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ilmu_pkg::APB_AW-1:0]    paddr,
  input  logic [ilmu_pkg::APB_DW-1:0]    pwdata,
  output logic [ilmu_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  ilmu_pkg::cmd_t    cmd;
  ilmu_pkg::status_t status;

  assign pready = 1'b1;

  ilmu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (site.valid),
    .in_ready (site.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ilmu_datapath #(
    .LATTICE_SIDE (LATTICE_SIDE)
  ) u_datapath (
    .clk                     (clk),
    .rst                     (rst),
    .cmd                     (cmd),
    .status                  (status),
    .site_index              (site.site_index),
    .random_value            (site.random_value),
    .out_valid               (result.valid),
    .out_ready               (result.ready),
    .out_flipped             (result.flipped),
    .out_energy_change       (result.energy_change),
    .out_total_energy        (result.total_energy),
    .out_total_magnetization (result.total_magnetization),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata)
  );

endmodule
